// ===== design/ppmfg_pkg.sv =====
// ppmfg_pkg: shared types and constants of the ppm frame generator
`default_nettype none

package ppmfg_pkg;

   localparam int CHAN_W       = 12;
   localparam int TICK_W       = 16;
   localparam int MODE_W       = 8;
   localparam int MODE_SEL_W   = 3;
   localparam int MODE_COUNT   = 6;
   localparam int INPUT_CHANS  = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [TICK_W-1:0]     FRAME_LEN_RST = 16'd22500;
   localparam logic [CHAN_W-1:0]     PULSE_LEN_RST = 12'd300;
   localparam logic [CHAN_W-1:0]     DEFAULT_WIDTH = 12'd1500;
   localparam logic [MODE_W-1:0]     MODE_BYTE_RST = 8'h01;
   localparam logic [MODE_SEL_W-1:0] MODE_SEL_RST  = 3'd0;

   localparam logic [MODE_W-1:0] MODE_CODES [MODE_COUNT] =
      '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_LEN   = 2'd0,
      CSR_PULSE_LEN   = 2'd1,
      CSR_ACTIVE_HIGH = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel_0_us;
      logic [CHAN_W-1:0] channel_1_us;
      logic [CHAN_W-1:0] channel_2_us;
      logic [CHAN_W-1:0] channel_3_us;
      logic [MODE_W-1:0] button_byte;
   } req_type;

   typedef struct packed {
      logic                  ppm_level;
      logic [MODE_W-1:0]     mode_leds;
      logic [MODE_SEL_W-1:0] mode_index;
   } rsp_type;

   // mode state after this tick's button check
   typedef struct packed {
      logic [MODE_W-1:0]     mode_byte;
      logic [MODE_SEL_W-1:0] mode_select;
   } mode_status_type;

   // last channel width for each mode
   function automatic logic [CHAN_W-1:0] mode_width(input logic [MODE_SEL_W-1:0] sel);
      logic [CHAN_W-1:0] w;
      unique case (sel)
         3'd0:    w = 12'd1080;
         3'd1:    w = 12'd1240;
         3'd2:    w = 12'd1400;
         3'd3:    w = 12'd1560;
         3'd4:    w = 12'd1740;
         3'd5:    w = 12'd1900;
         default: w = 12'd1080;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== design/ppmfg_mode_ctrl.sv =====
// ppmfg_mode_ctrl: mode button decode and mode state registers
`default_nettype none

module ppmfg_mode_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [ppmfg_pkg::MODE_W-1:0]  button_byte,
   output ppmfg_pkg::mode_status_type         mode_next
);
   import ppmfg_pkg::*;

   logic [MODE_W-1:0]     mode_byte_ff,   mode_byte_in;
   logic [MODE_SEL_W-1:0] mode_select_ff, mode_select_in;

   // codes are distinct, so at most one matches
   always_comb begin
      mode_byte_in   = mode_byte_ff;
      mode_select_in = mode_select_ff;
      for (int i = 0; i < MODE_COUNT; i++) begin
         if (button_byte == MODE_CODES[i]) begin
            mode_byte_in   = button_byte;
            mode_select_in = MODE_SEL_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_byte_ff   <= MODE_BYTE_RST;
         mode_select_ff <= MODE_SEL_RST;
      end else if (advance) begin
         mode_byte_ff   <= mode_byte_in;
         mode_select_ff <= mode_select_in;
      end
   end

   assign mode_next.mode_byte   = mode_byte_in;
   assign mode_next.mode_select = mode_select_in;

endmodule

`default_nettype wire

// ===== design/ppm_frame_generator_core.sv =====
// ppm_frame_generator_core: top level of the ppm frame generator
// a req transfer reaches its rsp through the input register and then the result register
// throughput: one tick per cycle, one rsp per tick, with no bubbles under full flow
// a held rsp stalls the input register behind it, so req_ready drops after one more tick
// reset: line inactive, first pulse on tick START_DELAY, mode 0 (leds 0x01),
// frame length 22500, pulse length 300, active high polarity; no transfers taken in reset
`default_nettype none

module ppm_frame_generator_core #(
   parameter int NUM_CHANNELS = 5,
   parameter int START_DELAY  = 50
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tick input
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire ppmfg_pkg::req_type                req_data,
   // per-tick result
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output ppmfg_pkg::rsp_type                     rsp_data,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ppmfg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ppmfg_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ppmfg_pkg::*;

   // slot counter runs 0..NUM_CHANNELS, the top value marks the sync slot
   localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_CHANNELS - 1);
   localparam logic [SLOT_W-1:0] SYNC_SLOT = SLOT_W'(NUM_CHANNELS);

   // configuration registers
   logic [TICK_W-1:0] frame_len_ff;
   logic [CHAN_W-1:0] pulse_len_ff;
   logic              active_high_ff;

   // input stage
   logic    in_valid_ff;
   req_type in_data_ff;

   // timer state
   logic              in_pulse_ff,  in_pulse_in;
   logic [TICK_W-1:0] ticks_ff,     ticks_in;
   logic [SLOT_W-1:0] slot_ff,      slot_in;
   logic [TICK_W-1:0] frame_sum_ff, frame_sum_in;

   // result stage
   logic    out_valid_ff;
   rsp_type out_data_ff, out_data_in;

   logic            advance;
   mode_status_type mode_next;

   logic [CHAN_W-1:0] chan_w [INPUT_CHANS];
   logic [CHAN_W-1:0] slot_w;
   logic [TICK_W:0]   sum_wide;
   logic [TICK_W-1:0] sum_sat;
   logic [TICK_W:0]   sync_wide;
   logic [TICK_W-1:0] sync_total;

   // the result register moves on when empty or taken; the input stage follows it
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !reset && (!in_valid_ff || advance);
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff   <= FRAME_LEN_RST;
         pulse_len_ff   <= PULSE_LEN_RST;
         active_high_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_LEN:   frame_len_ff   <= csr_data;
            CSR_PULSE_LEN:   pulse_len_ff   <= csr_data[CHAN_W-1:0];
            CSR_ACTIVE_HIGH: active_high_ff <= csr_data[0];
            CSR_UNUSED:      ;
            default:         ;
         endcase
      end
   end

   // input register, payload without reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   ppmfg_mode_ctrl u_mode_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .button_byte (in_data_ff.button_byte),
      .mode_next   (mode_next)
   );

   assign chan_w[0] = in_data_ff.channel_0_us;
   assign chan_w[1] = in_data_ff.channel_1_us;
   assign chan_w[2] = in_data_ff.channel_2_us;
   assign chan_w[3] = in_data_ff.channel_3_us;

   // width of the slot whose pulse ends now; the last channel follows the mode
   always_comb begin
      priority if (slot_ff == LAST_SLOT) begin
         slot_w = mode_width(mode_next.mode_select);
      end else if ({1'b0, slot_ff} < (SLOT_W + 1)'(INPUT_CHANS)) begin
         slot_w = chan_w[slot_ff[1:0]];
      end else begin
         slot_w = DEFAULT_WIDTH;
      end
   end

   // frame sum saturates at full scale
   assign sum_wide   = {1'b0, frame_sum_ff} + (TICK_W + 1)'(slot_w);
   assign sum_sat    = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];
   assign sync_wide  = {1'b0, frame_sum_ff} + (TICK_W + 1)'(pulse_len_ff);
   assign sync_total = sync_wide[TICK_W] ? '1 : sync_wide[TICK_W-1:0];

   // phase sequencer: pulse, gap, next slot; a zero length lasts one tick
   always_comb begin
      in_pulse_in  = in_pulse_ff;
      ticks_in     = ticks_ff - 1'b1;
      slot_in      = slot_ff;
      frame_sum_in = frame_sum_ff;
      if (ticks_ff <= TICK_W'(1)) begin
         if (!in_pulse_ff) begin
            in_pulse_in = 1'b1;
            ticks_in    = TICK_W'(pulse_len_ff);
         end else begin
            in_pulse_in = 1'b0;
            if (slot_ff >= SYNC_SLOT) begin
               // sync gap pads to the frame length, clamped at zero
               ticks_in     = (frame_len_ff > sync_total) ? frame_len_ff - sync_total : '0;
               slot_in      = '0;
               frame_sum_in = '0;
            end else begin
               ticks_in     = (slot_w > pulse_len_ff) ?
                              TICK_W'(slot_w - pulse_len_ff) : '0;
               frame_sum_in = sum_sat;
               slot_in      = slot_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pulse_ff  <= 1'b0;
         ticks_ff     <= TICK_W'(START_DELAY);
         slot_ff      <= '0;
         frame_sum_ff <= '0;
      end else if (advance) begin
         in_pulse_ff  <= in_pulse_in;
         ticks_ff     <= ticks_in;
         slot_ff      <= slot_in;
         frame_sum_ff <= frame_sum_in;
      end
   end

   // result shows the state after the tick
   always_comb begin
      out_data_in.ppm_level  = in_pulse_in ? active_high_ff : !active_high_ff;
      out_data_in.mode_leds  = mode_next.mode_byte;
      out_data_in.mode_index = mode_next.mode_select;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
